FILE: rtl/sirt_pkg.sv
// Shared constants, types and state codes for the signed integer to radix text block.
package sirt_pkg;

    // Field and storage widths.
    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int RADIX_W    = 5;
    localparam int DIGIT_W    = 4;
    localparam int MAX_DIGITS = 32;
    localparam int STACK_W    = MAX_DIGITS * DIGIT_W;
    localparam int NDIG_W     = $clog2(MAX_DIGITS + 1);
    localparam int DIV_CNT_W  = $clog2(VALUE_W);
    localparam int SYM_W      = 128;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;

    // Radix limits and register reset values.
    localparam logic [RADIX_W-1:0]    RADIX_MIN     = 5'd2;
    localparam logic [RADIX_W-1:0]    RADIX_MAX     = 5'd16;
    localparam logic [RADIX_W-1:0]    RADIX_RST     = 5'd10;
    localparam logic [CFG_DATA_W-1:0] SYM_LOW_RST   = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] SYM_HIGH_RST  = 64'h4645444342413938;
    localparam logic [CHAR_W-1:0]     MINUS_CHAR    = 8'h2D;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_RADIX     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYM_LOW   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SYM_HIGH  = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_EMIT
    } t_state;

    // Result of one division by the radix.
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quot;
        logic [DIGIT_W-1:0] rem;
    } t_div_out;

endpackage

FILE: rtl/sirt_div.sv
// Bit-serial restoring divider: 32-bit magnitude divided by a radix of 2 to 16.
module sirt_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sirt_pkg::VALUE_W-1:0]  i_dividend,
    input  logic [sirt_pkg::RADIX_W-1:0]  i_divisor,
    output sirt_pkg::t_div_out            o_res
);

    logic                             r_busy;
    logic                             r_done;
    logic [sirt_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [sirt_pkg::VALUE_W-1:0]     r_quot;
    logic [sirt_pkg::DIGIT_W-1:0]     r_rem;

    logic [sirt_pkg::RADIX_W-1:0]     n_trial;
    logic                             n_qbit;
    logic [sirt_pkg::RADIX_W-1:0]     n_diff;

    // One quotient bit per cycle: shift the next dividend bit into the remainder.
    always_comb begin
        n_trial = {r_rem, r_quot[sirt_pkg::VALUE_W-1]};
        n_qbit  = (n_trial >= i_divisor);
        n_diff  = n_trial - i_divisor;
    end

    // Control: busy through 32 shift steps, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {sirt_pkg::DIV_CNT_W{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: quotient bits replace dividend bits as they shift out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_quot <= {r_quot[sirt_pkg::VALUE_W-2:0], n_qbit};
            r_rem  <= n_qbit ? n_diff[sirt_pkg::DIGIT_W-1:0]
                             : n_trial[sirt_pkg::DIGIT_W-1:0];
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;
    assign o_res.rem  = r_rem;

endmodule

FILE: rtl/signed_integer_to_radix_text.sv
// Top level: converts signed 32-bit words to text characters in a programmable radix.
//
// Channel   Direction  Payload                         Handshake
// s_axis    in         tdata[31:0] value (signed)      tvalid/tready
// m_axis    out        tdata[7:0] character, tlast     tvalid/tready
// cfg       in         addr 0 radix, 1 sym low, 2 high write enable, no wait
//
// Each digit costs one division in the bit-serial divider (start, 32 shift steps,
// result); the text of a number starts once all its digits are found, then one
// character per cycle (up to 33) leaves at the output while it is not stalled.
// Reset is synchronous and active low; the registers return to radix 10, "0-9A-F".
// A new word is taken only once the previous text has all entered the output
// register; a stalled output holds the current character and pauses emission.
module signed_integer_to_radix_text (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input words: [31:0] value.
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [sirt_pkg::VALUE_W-1:0]     i_s_axis_tdata,
    // Output words: [7:0] character.
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [sirt_pkg::CHAR_W-1:0]      o_m_axis_tdata,
    output logic                             o_m_axis_tlast,
    // Configuration writes.
    input  logic                             i_cfg_we,
    input  logic [sirt_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [sirt_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);

    sirt_pkg::t_state                  r_state;
    sirt_pkg::t_state                  n_state;

    logic [sirt_pkg::RADIX_W-1:0]      r_radix;
    logic [sirt_pkg::SYM_W-1:0]        r_sym;
    logic [sirt_pkg::RADIX_W-1:0]      r_base;
    logic                              r_neg;
    logic [sirt_pkg::VALUE_W-1:0]      r_mag;
    logic [sirt_pkg::STACK_W-1:0]      r_stk;
    logic [sirt_pkg::NDIG_W-1:0]       r_ndig;
    logic                              r_ovalid;
    logic [sirt_pkg::CHAR_W-1:0]       r_ochar;
    logic                              r_olast;

    logic [sirt_pkg::RADIX_W-1:0]      n_base;
    logic                              n_neg;
    logic [sirt_pkg::VALUE_W-1:0]      n_mag;
    logic [sirt_pkg::STACK_W-1:0]      n_stk;
    logic [sirt_pkg::NDIG_W-1:0]       n_ndig;
    logic                              n_ovalid;
    logic [sirt_pkg::CHAR_W-1:0]       n_ochar;
    logic                              n_olast;

    logic                              w_accept;
    logic                              w_load;
    logic                              w_div_start;
    logic                              w_digits_done;
    logic [sirt_pkg::DIGIT_W-1:0]      w_top_digit;
    sirt_pkg::t_div_out                w_div;

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_load      = !r_ovalid || i_m_axis_tready;
    assign w_div_start = (r_state == sirt_pkg::ST_START);
    assign w_top_digit = r_stk[sirt_pkg::DIGIT_W-1:0];
    assign w_digits_done = (w_div.quot == '0) ||
                           (r_ndig == sirt_pkg::NDIG_W'(sirt_pkg::MAX_DIGITS - 1));

    // Divider shared by every digit of a number.
    sirt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_base),
        .o_res      (w_div)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= sirt_pkg::RADIX_RST;
            r_sym   <= {sirt_pkg::SYM_HIGH_RST, sirt_pkg::SYM_LOW_RST};
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                sirt_pkg::CFG_RADIX: begin
                    r_radix <= i_cfg_wdata[sirt_pkg::RADIX_W-1:0];
                end
                sirt_pkg::CFG_SYM_LOW: begin
                    r_sym[sirt_pkg::CFG_DATA_W-1:0] <= i_cfg_wdata;
                end
                sirt_pkg::CFG_SYM_HIGH: begin
                    r_sym[sirt_pkg::SYM_W-1:sirt_pkg::CFG_DATA_W] <= i_cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sirt_pkg::ST_IDLE: begin
                if (w_accept) n_state = sirt_pkg::ST_START;
            end
            sirt_pkg::ST_START: begin
                n_state = sirt_pkg::ST_DIV;
            end
            sirt_pkg::ST_DIV: begin
                if (w_div.done) begin
                    n_state = w_digits_done ? sirt_pkg::ST_EMIT : sirt_pkg::ST_START;
                end
            end
            sirt_pkg::ST_EMIT: begin
                if (w_load && !r_neg && (r_ndig == sirt_pkg::NDIG_W'(1))) begin
                    n_state = sirt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sirt_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        n_base   = r_base;
        n_neg    = r_neg;
        n_mag    = r_mag;
        n_stk    = r_stk;
        n_ndig   = r_ndig;
        n_ovalid = r_ovalid && !i_m_axis_tready;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        case (r_state)
            sirt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    // Clamp the radix and form the unsigned magnitude.
                    if (r_radix < sirt_pkg::RADIX_MIN) begin
                        n_base = sirt_pkg::RADIX_MIN;
                    end else if (r_radix > sirt_pkg::RADIX_MAX) begin
                        n_base = sirt_pkg::RADIX_MAX;
                    end else begin
                        n_base = r_radix;
                    end
                    n_neg  = i_s_axis_tdata[sirt_pkg::VALUE_W-1];
                    n_mag  = n_neg ? (~i_s_axis_tdata + 1'b1) : i_s_axis_tdata;
                    n_ndig = '0;
                end
            end
            sirt_pkg::ST_DIV: begin
                // Push the new digit; the least significant ends deepest.
                if (w_div.done) begin
                    n_mag  = w_div.quot;
                    n_stk  = {r_stk[sirt_pkg::STACK_W-sirt_pkg::DIGIT_W-1:0], w_div.rem};
                    n_ndig = r_ndig + 1'b1;
                end
            end
            sirt_pkg::ST_EMIT: begin
                if (w_load) begin
                    n_ovalid = 1'b1;
                    if (r_neg) begin
                        n_ochar = sirt_pkg::MINUS_CHAR;
                        n_olast = 1'b0;
                        n_neg   = 1'b0;
                    end else begin
                        // Pop the most significant remaining digit.
                        n_ochar = r_sym[{w_top_digit, 3'b000} +: sirt_pkg::CHAR_W];
                        n_olast = (r_ndig == sirt_pkg::NDIG_W'(1));
                        n_stk   = {{sirt_pkg::DIGIT_W{1'b0}},
                                   r_stk[sirt_pkg::STACK_W-1:sirt_pkg::DIGIT_W]};
                        n_ndig  = r_ndig - 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sirt_pkg::ST_IDLE;
            r_ovalid <= 1'b0;
            r_neg    <= 1'b0;
            r_ndig   <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_neg    <= n_neg;
            r_ndig   <= n_ndig;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_base  <= n_base;
        r_mag   <= n_mag;
        r_stk   <= n_stk;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
    end

    assign o_s_axis_tready = (r_state == sirt_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_ochar;
    assign o_m_axis_tlast  = r_olast;

endmodule

FILE: tb/sv/tb_signed_integer_to_radix_text.sv
// Self-checking testbench for the signed integer to radix text converter.
module tb_signed_integer_to_radix_text;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS_PER_PHASE = 30;
    localparam int RANDOM_PHASES   = 12;
    localparam int DRAIN_CYCLES    = 1200;
    localparam longint CYCLE_LIMIT = 3_000_000;
    // The fourth register index decodes to nothing.
    localparam logic [sirt_pkg::CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    // One character of number text as it leaves the block.
    typedef struct packed {
        logic [sirt_pkg::CHAR_W-1:0] character;
        logic                        last;
    } t_text_char;

    typedef enum logic {
        ROW_WRITE,
        ROW_NUMBER
    } t_row_kind;

    // One line of the directed table: a register write or a number to convert.
    // An empty text means the expected characters come from the predictor.
    typedef struct {
        t_row_kind                         kind;
        logic [sirt_pkg::CFG_ADDR_W-1:0]   addr;
        logic [sirt_pkg::CFG_DATA_W-1:0]   wdata;
        logic [sirt_pkg::VALUE_W-1:0]      value;
        string                             text;
    } t_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_s_axis_tvalid;
    logic                              o_s_axis_tready;
    logic [sirt_pkg::VALUE_W-1:0]      i_s_axis_tdata;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready;
    logic [sirt_pkg::CHAR_W-1:0]       o_m_axis_tdata;
    logic                              o_m_axis_tlast;
    logic                              i_cfg_we;
    logic [sirt_pkg::CFG_ADDR_W-1:0]   i_cfg_addr;
    logic [sirt_pkg::CFG_DATA_W-1:0]   i_cfg_wdata;

    // Shadow copy of the block's registers.
    logic [sirt_pkg::RADIX_W-1:0]      radix_setting;
    logic [sirt_pkg::SYM_W-1:0]        symbol_table;

    t_text_char              expected_chars[$];
    t_row                    directed_rows[$];
    int                      mismatch_count = 0;
    int                      numbers_sent = 0;
    int                      chars_checked = 0;
    int                      settings_used = 0;
    longint                  cycle_count = 0;
    bit                      idle_enable = 1'b1;

    signed_integer_to_radix_text DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Works out the characters of one number under the current registers.
    function automatic void predict_text(input logic [sirt_pkg::VALUE_W-1:0] value);
        logic [sirt_pkg::RADIX_W-1:0]  base;
        logic [sirt_pkg::VALUE_W:0]    mag;
        logic [sirt_pkg::DIGIT_W-1:0]  digits[$];
        t_text_char                    entry;
        base = radix_setting;
        if (base < sirt_pkg::RADIX_MIN) base = sirt_pkg::RADIX_MIN;
        if (base > sirt_pkg::RADIX_MAX) base = sirt_pkg::RADIX_MAX;
        // The magnitude is 33 bits wide so the most negative value needs no special path.
        mag = value[sirt_pkg::VALUE_W-1] ? (33'h1_0000_0000 - {1'b0, value})
                                         : {1'b0, value};
        do begin
            digits.push_back(sirt_pkg::DIGIT_W'(mag % base));
            mag = mag / base;
        end while (mag != 0 && digits.size() < sirt_pkg::MAX_DIGITS);
        if (value[sirt_pkg::VALUE_W-1]) begin
            entry.character = sirt_pkg::MINUS_CHAR;
            entry.last = 1'b0;
            expected_chars.push_back(entry);
        end
        // Digits were found least significant first, so they leave from the back.
        while (digits.size() > 0) begin
            entry.character = symbol_table[digits[$] * sirt_pkg::CHAR_W +: sirt_pkg::CHAR_W];
            entry.last = (digits.size() == 1);
            expected_chars.push_back(entry);
            void'(digits.pop_back());
        end
    endfunction

    function automatic void write_row(input logic [sirt_pkg::CFG_ADDR_W-1:0] addr,
                                      input logic [sirt_pkg::CFG_DATA_W-1:0] data);
        t_row row;
        row.kind = ROW_WRITE;
        row.addr = addr;
        row.wdata = data;
        row.value = '0;
        row.text = "";
        directed_rows.push_back(row);
    endfunction

    function automatic void number_row(input logic [sirt_pkg::VALUE_W-1:0] value,
                                       input string text);
        t_row row;
        row.kind = ROW_NUMBER;
        row.addr = sirt_pkg::CFG_RADIX;
        row.wdata = '0;
        row.value = value;
        row.text = text;
        directed_rows.push_back(row);
    endfunction

    // Offers one number word and records its expected text once it is taken.
    // Entered and left at a falling edge; tvalid stays high on the way out.
    task automatic send_number(input logic [sirt_pkg::VALUE_W-1:0] value, input string text);
        t_text_char entry;
        while (idle_enable && $urandom_range(99) < 9) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= value;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (text.len() == 0) begin
            predict_text(value);
        end else begin
            for (int i = 0; i < text.len(); i++) begin
                entry.character = text[i];
                entry.last = (i == text.len() - 1);
                expected_chars.push_back(entry);
            end
        end
        numbers_sent++;
        @(negedge i_clk);
    endtask

    // Writes one register once all pending text has come out.
    task automatic write_register(input logic [sirt_pkg::CFG_ADDR_W-1:0] addr,
                                  input logic [sirt_pkg::CFG_DATA_W-1:0] data);
        i_s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        case (addr)
            sirt_pkg::CFG_RADIX: begin
                radix_setting = data[sirt_pkg::RADIX_W-1:0];
            end
            sirt_pkg::CFG_SYM_LOW: begin
                symbol_table[sirt_pkg::CFG_DATA_W-1:0] = data;
            end
            sirt_pkg::CFG_SYM_HIGH: begin
                symbol_table[sirt_pkg::SYM_W-1:sirt_pkg::CFG_DATA_W] = data;
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Output side stalls at random unless idling is switched off.
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_axis_tready <= !idle_enable || ($urandom_range(99) >= 9);
        end
    end

    // Compare each character word taken from the block with the oldest expectation.
    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_chars.size() == 0) begin
                $error("character: none expected, actual %h (last %b)",
                       o_m_axis_tdata, o_m_axis_tlast);
                mismatch_count++;
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (o_m_axis_tdata !== want.character) begin
                    $error("character: expected %h, actual %h", want.character, o_m_axis_tdata);
                    mismatch_count++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last: expected %b, actual %b", want.last, o_m_axis_tlast);
                    mismatch_count++;
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [sirt_pkg::VALUE_W-1:0] value;
        int                           shift;

        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = sirt_pkg::CFG_RADIX;
        i_cfg_wdata = '0;
        radix_setting = sirt_pkg::RADIX_RST;
        symbol_table = {sirt_pkg::SYM_HIGH_RST, sirt_pkg::SYM_LOW_RST};

        // Reset values: decimal with the usual digits.
        number_row(32'h0000_0000, "0");
        number_row(32'h7FFF_FFFF, "2147483647");
        number_row(32'h8000_0000, "-2147483648");
        number_row(32'hFFFF_FFFF, "-1");
        number_row(32'h0000_000A, "10");
        number_row(32'hFFFF_FFF6, "");
        // Largest and smallest radix at the extremes of the value.
        write_row(sirt_pkg::CFG_RADIX, 64'd16);
        number_row(32'h7FFF_FFFF, "7FFFFFFF");
        number_row(32'h8000_0000, "-80000000");
        number_row(32'hFEDC_BA98, "");
        write_row(sirt_pkg::CFG_RADIX, 64'd2);
        number_row(32'h8000_0000, "");
        number_row(32'h7FFF_FFFF, "");
        number_row(32'hFFFF_FFFF, "-1");
        // A radix below two behaves as binary.
        write_row(sirt_pkg::CFG_RADIX, 64'd0);
        number_row(32'h0000_0005, "101");
        write_row(sirt_pkg::CFG_RADIX, 64'd1);
        number_row(32'hFFFF_FFFA, "-110");
        // A radix above sixteen behaves as sixteen.
        write_row(sirt_pkg::CFG_RADIX, 64'd31);
        number_row(32'h0000_00FF, "FF");
        write_row(sirt_pkg::CFG_RADIX, 64'd17);
        number_row(32'h0000_0100, "100");
        // A write to the unused index must leave everything alone.
        write_row(CFG_UNUSED, 64'd5);
        number_row(32'h0000_0064, "64");
        write_row(sirt_pkg::CFG_RADIX, 64'd3);
        number_row(32'h8000_0000, "");
        // Odd symbols, including all-zero and all-one bytes, go out as stored.
        write_row(sirt_pkg::CFG_SYM_LOW, 64'h00FF_2D41_6162_3031);
        write_row(sirt_pkg::CFG_SYM_HIGH, 64'hFFFF_FFFF_0000_0000);
        write_row(sirt_pkg::CFG_RADIX, 64'd16);
        number_row(32'h0123_4567, "");
        number_row(32'h89AB_CDEF, "");
        number_row(32'h0000_0000, "");
        write_row(sirt_pkg::CFG_SYM_LOW, sirt_pkg::SYM_LOW_RST);
        write_row(sirt_pkg::CFG_SYM_HIGH, sirt_pkg::SYM_HIGH_RST);
        write_row(sirt_pkg::CFG_RADIX, 64'd10);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE) begin
                write_register(directed_rows[r].addr, directed_rows[r].wdata);
            end else begin
                send_number(directed_rows[r].value, directed_rows[r].text);
            end
        end

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            idle_enable = !(phase == 4 || phase == 5);
            write_register(sirt_pkg::CFG_RADIX,
                           64'(phase == 0 ? 2 : phase == 1 ? 16 :
                               phase == 2 ? 0 : $urandom_range(31)));
            if (phase % 3 == 1) begin
                write_register(sirt_pkg::CFG_SYM_LOW, {$urandom, $urandom});
                write_register(sirt_pkg::CFG_SYM_HIGH, {$urandom, $urandom});
            end else if (phase % 3 == 2) begin
                write_register(sirt_pkg::CFG_SYM_LOW, sirt_pkg::SYM_LOW_RST);
                write_register(sirt_pkg::CFG_SYM_HIGH, sirt_pkg::SYM_HIGH_RST);
            end
            settings_used++;
            repeat (ITEMS_PER_PHASE) begin
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: value = $urandom;
                    5, 6: value = $urandom_range(200) - 100;
                    7: begin
                        case ($urandom_range(3))
                            0: value = 32'h8000_0000;
                            1: value = 32'h7FFF_FFFF;
                            2: value = 32'h0000_0000;
                            default: value = 32'hFFFF_FFFF;
                        endcase
                    end
                    8: begin
                        // Powers of two and their neighbors, either sign.
                        shift = $urandom_range(31);
                        value = (32'd1 << shift) - $urandom_range(1);
                        if ($urandom_range(1)) value = -value;
                    end
                    default: begin
                        value = $urandom >> $urandom_range(31);
                        if ($urandom_range(1)) value = ~value;
                    end
                endcase
                send_number(value, "");
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Converted %0d numbers into %0d checked characters.",
                 numbers_sent, chars_checked);
        $display("Random part ran under %0d register settings after the directed table.",
                 settings_used);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: signed_integer_to_radix_text.f
rtl/sirt_pkg.sv
rtl/sirt_div.sv
rtl/signed_integer_to_radix_text.sv
tb/sv/tb_signed_integer_to_radix_text.sv
